// ===== hdl/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

  // Map geometry: one used bit per block, 64 blocks to a map word.
  localparam int WORD_BITS = 64;
  localparam int WPOS_W    = 6;
  localparam int K_W       = 7;

  // Each metadata block of the on-disk bitmap covers this many blocks.
  localparam int BPMB       = 16384;
  localparam int BPMB_SHIFT = 14;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam word_t WORD_ONES = '1;
  localparam word_t MSB_BIT   = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Operation codes of an input item.
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_FORMAT = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_FREE  = 2'd3;

  // Request to the first-free search unit: candidate bits, MSB first, and
  // the number of leading positions that may be taken.
  typedef struct packed {
    word_t          cand;
    logic [K_W-1:0] lim;
  } ff_req_t;

  typedef struct packed {
    logic              found;
    logic [WPOS_W-1:0] pos;
  } ff_rsp_t;

  // Mask of the k leading (most significant) bits of a word.
  function automatic word_t top_mask(input logic [K_W-1:0] k);
    return ~(WORD_ONES >> k);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bba_ram.sv =====
`default_nettype none

module bba_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/bba_find_first.sv =====
`default_nettype none

module bba_find_first
  import bba_pkg::*;
(
  input  wire ff_req_t req_i,
  output ff_rsp_t      rsp_o
);

  word_t cand;

  // Keep only the permitted leading positions, then pick the one nearest the MSB.
  always_comb begin
    cand        = req_i.cand & top_mask(req_i.lim);
    rsp_o.found = |cand;
    rsp_o.pos   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[WORD_BITS-1-j]) begin
        rsp_o.pos = WPOS_W'(j);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bitmap_block_allocator_unit.sv =====
// First-fit block allocator over a bitmap of one used bit per block, 64 blocks
// to a map word, the lowest block of a word in its most significant bit. A
// second, smaller map holds one bit per map word that is set while that word
// still has a free block, so an allocation reads summary rows of 64 words one
// per cycle through a shared first-free search unit and then one map word.
// The maps hold nothing useful until a format item has run, so format first.
// An item passes from acceptance through a decode state and then to emit: a
// free checks its map word in between unless it is refused for its index, a
// bad operation goes straight to emit, and an allocation checks summary rows,
// each covering 4096 blocks, until one shows room or the partition ends, and
// then one map word; a format sweeps every map word, one a cycle. The input
// stalls while an item is in progress; a finished result waits in the output
// register while the next item is already being taken in. The configured size
// is saturated at MAX_BLOCKS, and should be followed by a format when changed.
`default_nettype none

module bitmap_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = 131072,
  localparam int IDX_W = $clog2(MAX_BLOCKS),
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       operation_i,
  input  wire logic [IDX_W-1:0] block_index_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [IDX_W-1:0] result_block_o,
  output logic      [1:0]       status_o,
  output logic      [CNT_W-1:0] free_count_o
);

  localparam int SW        = CNT_W + 1;
  localparam int MAP_AW    = IDX_W - WPOS_W;
  localparam int MAP_DEPTH = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int SUM_DEPTH = (MAP_DEPTH + WORD_BITS - 1) / WORD_BITS;
  localparam int SUM_AW    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
  localparam int SUM_CW    = $clog2(SUM_DEPTH + 1);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_DECODE    = 3'd1;
  localparam logic [2:0] ST_SUM_CHK   = 3'd2;
  localparam logic [2:0] ST_WORD_CHK  = 3'd3;
  localparam logic [2:0] ST_FREE_CHK  = 3'd4;
  localparam logic [2:0] ST_FORMAT    = 3'd5;
  localparam logic [2:0] ST_EMIT      = 3'd6;

  // Number of leading positions of a 64-wide span starting at base that lie
  // below top, clamped to 0..64.
  function automatic logic [K_W-1:0] span(input logic [SW-1:0] top,
                                         input logic [SW-1:0] base);
    logic [SW-1:0] d;
    d = top - base;
    if (top <= base) begin
      return '0;
    end else if (d >= SW'(WORD_BITS)) begin
      return K_W'(WORD_BITS);
    end else begin
      return K_W'(d);
    end
  endfunction

  // Control registers.
  logic [2:0]       state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] cfg_q, cfg_d;
  logic [CNT_W-1:0] used_q, used_d;

  // Payload registers.
  logic [1:0]        op_q, op_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  size_q, size_d;
  logic [SW-1:0]     lim_q, lim_d;
  logic [SUM_CW-1:0] row_q, row_d;
  logic [MAP_AW-1:0] word_q, word_d;
  word_t             sum_row_q, sum_row_d;
  logic [MAP_AW-1:0] fmt_q, fmt_d;
  logic [IDX_W-1:0]  res_blk_q, res_blk_d;
  logic [1:0]        res_st_q, res_st_d;
  logic [IDX_W-1:0]  out_blk_q, out_blk_d;
  logic [1:0]        out_st_q, out_st_d;
  logic [CNT_W-1:0]  out_free_q, out_free_d;

  // Memory ports.
  logic              map_we, sum_we;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic [SUM_AW-1:0] sum_waddr, sum_raddr;
  word_t             map_wdata, map_rdata, sum_wdata, sum_rdata;

  ff_req_t ff_req;
  ff_rsp_t ff_rsp;

  // Derived values.
  logic [CNT_W-1:0]  eff_size;
  logic [SW-1:0]     size_w, nwords, nfull, reserved, lim_new, fmt_base;
  logic [SUM_CW-1:0] row_nx;
  logic [MAP_AW-1:0] hit_word, idx_word;
  word_t             bit_m, new_word;

  assign eff_size = (cfg_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_q;
  assign size_w   = SW'(size_q);
  assign nwords   = (size_w + SW'(WORD_BITS - 1)) >> WPOS_W;
  assign nfull    = lim_q >> WPOS_W;
  assign reserved = SW'(1) + ((size_w + SW'(BPMB - 1)) >> BPMB_SHIFT);
  assign lim_new  = (reserved < size_w) ? reserved : size_w;
  assign fmt_base = SW'({fmt_q, {WPOS_W{1'b0}}});
  assign row_nx   = row_q + SUM_CW'(1);
  assign hit_word = MAP_AW'({row_q, ff_rsp.pos});
  assign idx_word = MAP_AW'(idx_q >> WPOS_W);

  bba_ram #(
    .DEPTH(MAP_DEPTH),
    .WIDTH(WORD_BITS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .raddr_i(map_raddr),
    .rdata_o(map_rdata)
  );

  bba_ram #(
    .DEPTH(SUM_DEPTH),
    .WIDTH(WORD_BITS)
  ) u_sum (
    .clk_i  (clk_i),
    .we_i   (sum_we),
    .waddr_i(sum_waddr),
    .wdata_i(sum_wdata),
    .raddr_i(sum_raddr),
    .rdata_o(sum_rdata)
  );

  bba_find_first u_ff (
    .req_i(ff_req),
    .rsp_o(ff_rsp)
  );

  // Sequencer: one item at a time through decode, a search, check or sweep, then emit.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    cfg_d       = cfg_q;
    used_d      = used_q;
    op_d        = op_q;
    idx_d       = idx_q;
    size_d      = size_q;
    lim_d       = lim_q;
    row_d       = row_q;
    word_d      = word_q;
    sum_row_d   = sum_row_q;
    fmt_d       = fmt_q;
    res_blk_d   = res_blk_q;
    res_st_d    = res_st_q;
    out_blk_d   = out_blk_q;
    out_st_d    = out_st_q;
    out_free_d  = out_free_q;

    map_we      = 1'b0;
    map_waddr   = word_q;
    map_wdata   = '0;
    map_raddr   = word_q;
    sum_we      = 1'b0;
    sum_waddr   = SUM_AW'(word_q >> WPOS_W);
    sum_wdata   = '0;
    sum_raddr   = row_q[SUM_AW-1:0];

    ff_req.cand = ~map_rdata;
    ff_req.lim  = span(size_w, SW'({word_q, {WPOS_W{1'b0}}}));
    bit_m       = MSB_BIT >> ff_rsp.pos;
    new_word    = map_rdata | bit_m;

    if (cfg_we_i) begin
      cfg_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          idx_d   = block_index_i;
          size_d  = eff_size;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_blk_d = '0;
        res_st_d  = STAT_OK;
        unique case (op_q)
          OP_ALLOC: begin
            row_d     = '0;
            sum_raddr = '0;
            state_d   = ST_SUM_CHK;
          end
          OP_FREE: begin
            map_raddr = idx_word;
            sum_raddr = SUM_AW'(idx_q >> (2 * WPOS_W));
            if ((SW'(idx_q) >= size_w) || (SW'(idx_q) < reserved)) begin
              res_st_d = STAT_RANGE;
              state_d  = ST_EMIT;
            end else begin
              state_d  = ST_FREE_CHK;
            end
          end
          OP_FORMAT: begin
            lim_d   = lim_new;
            used_d  = CNT_W'(lim_new);
            fmt_d   = '0;
            state_d = ST_FORMAT;
          end
          default: begin
            res_st_d = STAT_RANGE;
            state_d  = ST_EMIT;
          end
        endcase
      end

      // Summary row in hand: find the first word below the size with a free block.
      ST_SUM_CHK: begin
        ff_req.cand = sum_rdata;
        ff_req.lim  = span(nwords, SW'({row_q, {WPOS_W{1'b0}}}));
        if (ff_rsp.found) begin
          word_d    = hit_word;
          map_raddr = hit_word;
          sum_row_d = sum_rdata;
          state_d   = ST_WORD_CHK;
        end else if (SW'({row_nx, {WPOS_W{1'b0}}}) >= nwords) begin
          res_st_d = STAT_FULL;
          state_d  = ST_EMIT;
        end else begin
          row_d     = row_nx;
          sum_raddr = row_nx[SUM_AW-1:0];
        end
      end

      // Map word in hand: take its first free block below the size.
      ST_WORD_CHK: begin
        if (ff_rsp.found) begin
          map_we    = 1'b1;
          map_waddr = word_q;
          map_wdata = new_word;
          if (&new_word) begin
            sum_we    = 1'b1;
            sum_waddr = SUM_AW'(word_q >> WPOS_W);
            sum_wdata = sum_row_q & ~(MSB_BIT >> WPOS_W'(word_q));
          end
          used_d    = used_q + CNT_W'(1);
          res_blk_d = IDX_W'({word_q, ff_rsp.pos});
        end else begin
          res_st_d = STAT_FULL;
        end
        state_d = ST_EMIT;
      end

      // If the block is in use, clear its used bit and mark its word as having room; else report it as already free.
      ST_FREE_CHK: begin
        bit_m = MSB_BIT >> idx_q[WPOS_W-1:0];
        if (!(|(map_rdata & bit_m))) begin
          res_st_d = STAT_FREE;
        end else begin
          map_we    = 1'b1;
          map_waddr = idx_word;
          map_wdata = map_rdata & ~bit_m;
          sum_we    = 1'b1;
          sum_waddr = SUM_AW'(idx_q >> (2 * WPOS_W));
          sum_wdata = sum_rdata | (MSB_BIT >> WPOS_W'(idx_word));
          if (used_q != '0) begin
            used_d = used_q - CNT_W'(1);
          end
          res_blk_d = idx_q;
        end
        state_d = ST_EMIT;
      end

      // Sweep: rewrite every map word, and every summary row on the way.
      ST_FORMAT: begin
        map_we    = 1'b1;
        map_waddr = fmt_q;
        map_wdata = top_mask(span(lim_q, fmt_base));
        if (SW'(fmt_q) < SW'(SUM_DEPTH)) begin
          sum_we    = 1'b1;
          sum_waddr = SUM_AW'(fmt_q);
          sum_wdata = top_mask(span(SW'(MAP_DEPTH), fmt_base))
                      & ~top_mask(span(nfull, fmt_base));
        end
        if (fmt_q == MAP_AW'(MAP_DEPTH - 1)) begin
          state_d = ST_EMIT;
        end else begin
          fmt_d = fmt_q + MAP_AW'(1);
        end
      end

      // Hand the item's result to the output register once it has room.
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_blk_d   = res_blk_q;
          out_st_d    = res_st_q;
          out_free_d  = (size_q > used_q) ? (size_q - used_q) : '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cfg_q       <= CNT_W'(MAX_BLOCKS);
      used_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
      used_q      <= used_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    idx_q      <= idx_d;
    size_q     <= size_d;
    lim_q      <= lim_d;
    row_q      <= row_d;
    word_q     <= word_d;
    sum_row_q  <= sum_row_d;
    fmt_q      <= fmt_d;
    res_blk_q  <= res_blk_d;
    res_st_q   <= res_st_d;
    out_blk_q  <= out_blk_d;
    out_st_q   <= out_st_d;
    out_free_q <= out_free_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_block_o = out_blk_q;
  assign status_o       = out_st_q;
  assign free_count_o   = out_free_q;

endmodule

`default_nettype wire
